>>> sv/deq_pkg.sv
`default_nettype none
package deq_pkg;

	// Default number of stored words and the fixed word width.
	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;

	// Command codes carried by an input beat.
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_LIST       = 3'd4
	} deq_code_t;

	// Status codes carried by a result beat.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} deq_status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_LIST
	} deq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        wr_front;
		logic        wr_rear;
		logic        rd_front;
		logic        rd_rear;
		logic        list_first;
		logic        list_next;
		logic        load_imm;
		deq_status_t imm_status;
		logic        load_mem;
		logic        mem_last;
	} deq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic slot_free;
		logic list_done;
	} deq_stat_t;

endpackage
`default_nettype wire

>>> sv/deq_ram.sv
`default_nettype none
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/deq_ctrl.sv
`default_nettype none
module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_ready,
	input  wire logic [2:0] command,
	input  wire deq_stat_t stat,
	output      deq_cmd_t  cmd
);

	deq_state_t state_q;
	deq_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.imm_status = ST_OK;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				// A beat is taken only when the result slot can accept its answer.
				in_ready = stat.slot_free;
				if (in_valid && stat.slot_free) begin
					case (command)
						CMD_PUSH_FRONT: begin
							cmd.load_imm = 1'b1;
							if (stat.full) begin
								cmd.imm_status = ST_FULL;
							end else begin
								cmd.wr_front = 1'b1;
							end
						end
						CMD_PUSH_REAR: begin
							cmd.load_imm = 1'b1;
							if (stat.full) begin
								cmd.imm_status = ST_FULL;
							end else begin
								cmd.wr_rear = 1'b1;
							end
						end
						CMD_POP_FRONT: begin
							if (stat.empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.rd_front = 1'b1;
								state_d      = S_POP;
							end
						end
						CMD_POP_REAR: begin
							if (stat.empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.rd_rear = 1'b1;
								state_d     = S_POP;
							end
						end
						CMD_LIST: begin
							if (stat.empty) begin
								cmd.load_imm   = 1'b1;
								cmd.imm_status = ST_EMPTY;
							end else begin
								cmd.list_first = 1'b1;
								state_d        = S_LIST;
							end
						end
						default: begin
							// Unused codes answer with a plain acknowledgement.
							cmd.load_imm = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				// The popped word is in the read register; hand it over.
				if (stat.slot_free) begin
					cmd.load_mem = 1'b1;
					cmd.mem_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_LIST: begin
				// Emit one listed word and fetch the next while the receiver takes them.
				if (stat.slot_free) begin
					cmd.load_mem = 1'b1;
					cmd.mem_last = stat.list_done;
					if (stat.list_done) begin
						state_d = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/deq_dp.sv
`default_nettype none
module deq_dp
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic signed [DATA_W-1:0]   data_in,
	input  wire deq_cmd_t                   cmd,
	output      deq_stat_t                  stat,
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	output      logic [1:0]                 status,
	output      logic signed [DATA_W-1:0]   data_out,
	output      logic [$clog2(DEPTH+1)-1:0] occupancy,
	output      logic                       last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0] head_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] idx_q;

	logic [SW-1:0] rear_sum;
	logic [SW-1:0] rear_wrap;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] tail_wrap;
	logic [SW-1:0] idx_sum;
	logic [SW-1:0] idx_wrap;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_dec;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic              out_valid_q;
	deq_status_t       status_q;
	logic [DATA_W-1:0] data_q;
	logic [CW-1:0]     occ_q;
	logic              last_q;

	// Circular index arithmetic; used sums stay below twice the depth.
	always_comb begin
		rear_sum  = SW'(head_q) + SW'(count_q);
		rear_wrap = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
		tail_sum  = rear_sum - SW'(1);
		tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
		idx_sum   = SW'(head_q) + SW'(idx_q);
		idx_wrap  = (idx_sum >= SW'(DEPTH)) ? idx_sum - SW'(DEPTH) : idx_sum;
		head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
		head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	end

	// Store port selection.
	always_comb begin
		ram_we    = cmd.wr_front | cmd.wr_rear;
		ram_waddr = cmd.wr_front ? head_dec : rear_wrap[AW-1:0];
		ram_re    = cmd.rd_front | cmd.rd_rear | cmd.list_first | cmd.list_next;
		if (cmd.rd_rear) begin
			ram_raddr = tail_wrap[AW-1:0];
		end else if (cmd.list_next) begin
			ram_raddr = idx_wrap[AW-1:0];
		end else begin
			ram_raddr = head_q;
		end
	end

	// Next head and count.
	always_comb begin
		head_d  = head_q;
		count_d = count_q;
		if (cmd.wr_front) begin
			head_d  = head_dec;
			count_d = count_q + CW'(1);
		end else if (cmd.wr_rear) begin
			count_d = count_q + CW'(1);
		end else if (cmd.rd_front) begin
			head_d  = head_inc;
			count_d = count_q - CW'(1);
		end else if (cmd.rd_rear) begin
			count_d = count_q - CW'(1);
		end
	end

	// Queue pointers and the list walk index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
			if (cmd.list_first) begin
				idx_q <= CW'(1);
			end else if (cmd.list_next) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	deq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (data_in),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_imm || cmd.load_mem) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_imm) begin
			status_q <= cmd.imm_status;
			data_q   <= '0;
			occ_q    <= count_d;
			last_q   <= 1'b1;
		end else if (cmd.load_mem) begin
			status_q <= ST_OK;
			data_q   <= ram_rdata;
			occ_q    <= count_d;
			last_q   <= cmd.mem_last;
		end
	end

	// Status towards the controller.
	always_comb begin
		stat.empty     = (count_q == '0);
		stat.full      = (count_q == CW'(DEPTH));
		stat.slot_free = !out_valid_q || out_ready;
		stat.list_done = (idx_q == count_q);
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_q;
	assign occupancy = occ_q;
	assign last      = last_q;

endmodule
`default_nettype wire

>>> sv/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words in a circular store.
// Input channel (in_valid/in_ready) carries one command per beat: push front,
// push rear, pop front, pop rear or list; data_in is used by pushes only.
// Output channel (out_valid/out_ready) carries result beats with status,
// data_out, occupancy after the command and last on the final beat.
// Pushes, failed pops, an empty list and unused codes give one result in the
// cycle after acceptance, and a new command can follow if the receiver takes it.
// A pop reads the store through its registered read port first, so its result
// passes the read register and then the output register, and no new command is
// taken until that result is loaded. A list of N words gives N beats, one per
// cycle while the receiver takes them, each read through the store read port.
// Reset empties the queue and drops any waiting result; the store contents are
// not cleared, as no entry is read before it is written.
// While the receiver stalls, the waiting result holds in the output register
// and no further command or list beat is taken until it is accepted.
`default_nettype none
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire logic [2:0]                 command,
	input  wire logic signed [DATA_W-1:0]   data_in,
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	output      logic [1:0]                 status,
	output      logic signed [DATA_W-1:0]   data_out,
	output      logic [$clog2(DEPTH+1)-1:0] occupancy,
	output      logic                       last
);

	deq_cmd_t  cmd;
	deq_stat_t stat;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_in   (data_in),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data_out  (data_out),
		.occupancy (occupancy),
		.last      (last)
	);

endmodule
`default_nettype wire
